[rtl/jerk_shock_alarm_assert.svh]
// ----------------------------------------------------------------------------
// jerk shock alarm assertion macros
// shared assertion wrappers, clocked on clk, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef JERK_SHOCK_ALARM_ASSERT_SVH
`define JERK_SHOCK_ALARM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define JSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define JSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSA_ASSERT(lbl, prop, msg)
`define JSA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/jsa_pkg.sv]
// ----------------------------------------------------------------------------
// jsa_pkg
// types, constants and codes shared by the jerk shock alarm modules
// ----------------------------------------------------------------------------
`default_nettype none

package jsa_pkg;

  localparam int AXIS_W    = 16;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 24;
  localparam int TONE_W    = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // shared multiplier and accumulators
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int D2_W   = 34;
  localparam int TD_W   = THR_W + TIME_W;
  localparam int CMP_W  = 2 * TD_W + 2;
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(14);

  // microseconds per second, squared
  localparam logic [39:0] US_SQ = 40'hE8D4A51000;

  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(3276800);
  localparam logic [TONE_W-1:0] PERIOD_RESET = TONE_W'(1000);
  localparam logic [TONE_W-1:0] ON_RESET     = TONE_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JERK_THRESHOLD = 2'd0,
    REG_TONE_PERIOD    = 2'd1,
    REG_TONE_ON        = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_28 = 2'd2,
    SH_56 = 2'd3
  } shift_t;

  typedef enum logic [1:0] {
    DST_D2  = 2'd0,
    DST_TD  = 2'd1,
    DST_CMP = 2'd2
  } dest_t;

  typedef struct packed {
    logic                     kind;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [TIME_W-1:0]        time_us;
    logic                     button_pressed;
  } in_item_t;

  typedef struct packed {
    logic alarm_latched;
    logic buzzer_on;
    logic tone_start;
  } out_item_t;

  typedef struct packed {
    logic             issue;
    dest_t            dest;
    shift_t           shift;
    logic             sub;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mac_op_t;

  typedef struct packed {
    logic tick;
    logic button;
  } tone_ctl_t;

  typedef struct packed {
    logic start;
    logic buzz_tick;
    logic buzz_now;
  } tone_stat_t;

endpackage

`default_nettype wire

[rtl/jsa_mac.sv]
// ----------------------------------------------------------------------------
// jsa_mac
// shared 28x28 multiplier with a product register and three accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module jsa_mac (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clear,
  input  wire jsa_pkg::mac_op_t          op,
  output logic [jsa_pkg::D2_W-1:0]       d2,
  output logic [jsa_pkg::TD_W-1:0]       td,
  output logic                           cmp_neg
);

  logic [jsa_pkg::PROD_W-1:0] prod;
  logic                       p_issue;
  jsa_pkg::dest_t             p_dest;
  jsa_pkg::shift_t            p_shift;
  logic                       p_sub;
  logic [jsa_pkg::CMP_W-1:0]  wide;
  logic [jsa_pkg::CMP_W-1:0]  cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_issue <= 1'b0;
    end else begin
      p_issue <= op.issue;
    end
    prod    <= jsa_pkg::PROD_W'(op.a) * jsa_pkg::PROD_W'(op.b);
    p_dest  <= op.dest;
    p_shift <= op.shift;
    p_sub   <= op.sub;
  end

  always_comb begin
    case (p_shift)
      jsa_pkg::SH_0:  wide = jsa_pkg::CMP_W'(prod);
      jsa_pkg::SH_16: wide = jsa_pkg::CMP_W'(prod) << 16;
      jsa_pkg::SH_28: wide = jsa_pkg::CMP_W'(prod) << 28;
      jsa_pkg::SH_56: wide = jsa_pkg::CMP_W'(prod) << 56;
      default:        wide = '0;
    endcase
  end

  // difference of both sides of the trip test builds up in cmp
  always_ff @(posedge clk) begin
    if (clear) begin
      d2  <= '0;
      td  <= '0;
      cmp <= '0;
    end else if (p_issue) begin
      case (p_dest)
        jsa_pkg::DST_D2:  d2  <= d2 + wide[jsa_pkg::D2_W-1:0];
        jsa_pkg::DST_TD:  td  <= td + wide[jsa_pkg::TD_W-1:0];
        jsa_pkg::DST_CMP: cmp <= p_sub ? cmp - wide : cmp + wide;
        default: ;
      endcase
    end
  end

  assign cmp_neg = cmp[jsa_pkg::CMP_W-1];

endmodule

`default_nettype wire

[rtl/jsa_tone.sv]
// ----------------------------------------------------------------------------
// jsa_tone
// buzzer timing on millisecond ticks while the alarm is latched
// ----------------------------------------------------------------------------
`default_nettype none

module jsa_tone (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire jsa_pkg::tone_ctl_t          ctl,
  input  wire logic [jsa_pkg::TONE_W-1:0]  period,
  input  wire logic [jsa_pkg::TONE_W-1:0]  on_ms,
  output jsa_pkg::tone_stat_t              stat
);

  logic                       rearm;
  logic                       rearm_next;
  logic [jsa_pkg::TONE_W-1:0] ms;
  logic [jsa_pkg::TONE_W-1:0] ms_next;
  logic [jsa_pkg::TONE_W-1:0] ms_inc;
  logic                       start;

  // saturating tick count
  assign ms_inc = (ms != '1) ? ms + 1'b1 : ms;

  always_comb begin
    rearm_next = rearm;
    ms_next    = ms;
    start      = 1'b0;
    if (ctl.tick) begin
      if (ctl.button) begin
        rearm_next = 1'b1;
      end else if (rearm) begin
        rearm_next = 1'b0;
        ms_next    = '0;
        start      = 1'b1;
      end else if (ms_inc >= period) begin
        ms_next = '0;
        start   = 1'b1;
      end else begin
        ms_next = ms_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rearm <= 1'b1;
      ms    <= '0;
    end else begin
      rearm <= rearm_next;
      ms    <= ms_next;
    end
  end

  assign stat.start     = start;
  assign stat.buzz_tick = !rearm_next && (ms_next < on_ms);
  assign stat.buzz_now  = !rearm && (ms < on_ms);

endmodule

`default_nettype wire

[rtl/jerk_shock_alarm.sv]
// ----------------------------------------------------------------------------
// jerk_shock_alarm
// latches an alarm when the rate of change of acceleration reaches a threshold
// ----------------------------------------------------------------------------
// Every input item gives one result. Ticks, the first sample after reset or
// rearm, and samples while the alarm is latched need no comparison: their
// result is loaded into the output register as the item is taken. A sample
// that is compared against the previous one runs the exact test |d|^2 * 10^12
// >= (jerk_threshold * dt)^2 as 13 partial products through one shared 28x28
// multiplier and its accumulators, then drains the product pipeline and posts
// the result. A new item is taken only while the output register is empty or
// is read in the same cycle, and never while a comparison runs. There is no
// clearing pass after reset. Configuration is written through cfg_write,
// cfg_index and cfg_data; an unknown index is ignored.
`default_nettype none
`include "jerk_shock_alarm_assert.svh"

module jerk_shock_alarm (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire jsa_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output jsa_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_write,
  input  wire logic [jsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jsa_pkg::CFG_W-1:0]     cfg_data
);

  jsa_pkg::state_t                state;
  logic [jsa_pkg::STEP_W-1:0]     cnt;
  logic [jsa_pkg::THR_W-1:0]      thr;
  logic [jsa_pkg::TONE_W-1:0]     period;
  logic [jsa_pkg::TONE_W-1:0]     on_ms;
  logic                           alarm;
  logic                           first_sample;
  logic [jsa_pkg::AXIS_W-1:0]     prev_x;
  logic [jsa_pkg::AXIS_W-1:0]     prev_y;
  logic [jsa_pkg::AXIS_W-1:0]     prev_z;
  logic [jsa_pkg::TIME_W-1:0]     prev_time;
  logic [jsa_pkg::AXIS_W-1:0]     abs_x;
  logic [jsa_pkg::AXIS_W-1:0]     abs_y;
  logic [jsa_pkg::AXIS_W-1:0]     abs_z;
  logic [jsa_pkg::TIME_W-1:0]     dt;

  logic [jsa_pkg::AXIS_W:0]       dx;
  logic [jsa_pkg::AXIS_W:0]       dy;
  logic [jsa_pkg::AXIS_W:0]       dz;
  logic                           acc;
  logic                           is_tick;
  logic                           start_cmp;
  logic                           trip;
  logic                           out_load;
  jsa_pkg::out_item_t             out_next;

  jsa_pkg::mac_op_t               op;
  logic [jsa_pkg::D2_W-1:0]       d2;
  logic [jsa_pkg::TD_W-1:0]       td;
  logic                           cmp_neg;
  jsa_pkg::tone_ctl_t             tone_ctl;
  jsa_pkg::tone_stat_t            tone_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= jsa_pkg::THR_RESET;
      period <= jsa_pkg::PERIOD_RESET;
      on_ms  <= jsa_pkg::ON_RESET;
    end else if (cfg_write) begin
      case (jsa_pkg::cfg_reg_t'(cfg_index))
        jsa_pkg::REG_JERK_THRESHOLD: thr    <= cfg_data;
        jsa_pkg::REG_TONE_PERIOD:    period <= cfg_data[jsa_pkg::TONE_W-1:0];
        jsa_pkg::REG_TONE_ON:        on_ms  <= cfg_data[jsa_pkg::TONE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == jsa_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign acc       = in_valid && in_ready;
  assign is_tick   = in_data.kind;
  assign start_cmp = acc && !is_tick && !alarm && !first_sample;

  // per-axis change, magnitude fits 16 bits
  assign dx = {in_data.accel_x[jsa_pkg::AXIS_W-1], in_data.accel_x}
            - {prev_x[jsa_pkg::AXIS_W-1], prev_x};
  assign dy = {in_data.accel_y[jsa_pkg::AXIS_W-1], in_data.accel_y}
            - {prev_y[jsa_pkg::AXIS_W-1], prev_y};
  assign dz = {in_data.accel_z[jsa_pkg::AXIS_W-1], in_data.accel_z}
            - {prev_z[jsa_pkg::AXIS_W-1], prev_z};

  assign tone_ctl.tick   = acc && is_tick && alarm;
  assign tone_ctl.button = in_data.button_pressed;

  jsa_tone u_tone (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tone_ctl),
    .period (period),
    .on_ms  (on_ms),
    .stat   (tone_stat)
  );

  // partial product schedule for the shared multiplier
  always_comb begin
    op       = '0;
    op.dest  = jsa_pkg::DST_CMP;
    op.shift = jsa_pkg::SH_0;
    if (state == jsa_pkg::ST_BUSY) begin
      unique case (cnt)
        4'd0: begin
          op = '{1'b1, jsa_pkg::DST_D2, jsa_pkg::SH_0, 1'b0,
                 jsa_pkg::MUL_W'(abs_x), jsa_pkg::MUL_W'(abs_x)};
        end
        4'd1: begin
          op = '{1'b1, jsa_pkg::DST_D2, jsa_pkg::SH_0, 1'b0,
                 jsa_pkg::MUL_W'(abs_y), jsa_pkg::MUL_W'(abs_y)};
        end
        4'd2: begin
          op = '{1'b1, jsa_pkg::DST_D2, jsa_pkg::SH_0, 1'b0,
                 jsa_pkg::MUL_W'(abs_z), jsa_pkg::MUL_W'(abs_z)};
        end
        4'd3: begin
          op = '{1'b1, jsa_pkg::DST_TD, jsa_pkg::SH_0, 1'b0,
                 jsa_pkg::MUL_W'(thr), jsa_pkg::MUL_W'(dt[15:0])};
        end
        4'd4: begin
          op = '{1'b1, jsa_pkg::DST_TD, jsa_pkg::SH_16, 1'b0,
                 jsa_pkg::MUL_W'(thr), jsa_pkg::MUL_W'(dt[31:16])};
        end
        4'd5: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_0, 1'b0,
                 d2[27:0], jsa_pkg::US_SQ[27:0]};
        end
        4'd6: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_28, 1'b0,
                 d2[27:0], jsa_pkg::MUL_W'(jsa_pkg::US_SQ[39:28])};
        end
        4'd7: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_28, 1'b0,
                 jsa_pkg::MUL_W'(d2[33:28]), jsa_pkg::US_SQ[27:0]};
        end
        4'd8: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_56, 1'b0,
                 jsa_pkg::MUL_W'(d2[33:28]), jsa_pkg::MUL_W'(jsa_pkg::US_SQ[39:28])};
        end
        4'd9: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_0, 1'b1, td[27:0], td[27:0]};
        end
        4'd10: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_28, 1'b1, td[27:0], td[55:28]};
        end
        4'd11: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_28, 1'b1, td[55:28], td[27:0]};
        end
        4'd12: begin
          op = '{1'b1, jsa_pkg::DST_CMP, jsa_pkg::SH_56, 1'b1, td[55:28], td[55:28]};
        end
        default: ;
      endcase
    end
  end

  jsa_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .clear   (start_cmp),
    .op      (op),
    .d2      (d2),
    .td      (td),
    .cmp_neg (cmp_neg)
  );

  // zero time step trips on any change
  assign trip = (dt == '0) ? (d2 != '0) : !cmp_neg;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (acc) begin
      out_load = !start_cmp;
      if (is_tick) begin
        out_next.alarm_latched = alarm && !in_data.button_pressed;
        out_next.buzzer_on     = alarm && !in_data.button_pressed && tone_stat.buzz_tick;
        out_next.tone_start    = tone_stat.start;
      end else begin
        out_next.alarm_latched = alarm;
        out_next.buzzer_on     = alarm && tone_stat.buzz_now;
      end
    end else if (state == jsa_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_load               = 1'b1;
      out_next.alarm_latched = alarm;
      out_next.buzzer_on     = alarm && tone_stat.buzz_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= jsa_pkg::ST_IDLE;
      cnt          <= '0;
      alarm        <= 1'b0;
      first_sample <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        jsa_pkg::ST_IDLE: begin
          if (acc) begin
            if (is_tick) begin
              if (alarm && in_data.button_pressed) begin
                alarm        <= 1'b0;
                first_sample <= 1'b1;
              end
            end else if (!alarm) begin
              first_sample <= 1'b0;
              if (start_cmp) begin
                state <= jsa_pkg::ST_BUSY;
                cnt   <= '0;
              end
            end
          end
        end
        jsa_pkg::ST_BUSY: begin
          cnt <= cnt + 1'b1;
          if (cnt == jsa_pkg::LAST_STEP) begin
            alarm <= alarm || trip;
            state <= jsa_pkg::ST_DONE;
          end
        end
        jsa_pkg::ST_DONE: begin
          if (out_load) begin
            state <= jsa_pkg::ST_IDLE;
          end
        end
        default: state <= jsa_pkg::ST_IDLE;
      endcase
    end
  end

  // sample history and operands, loaded on every stored sample
  always_ff @(posedge clk) begin
    if (acc && !is_tick && !alarm) begin
      prev_x    <= in_data.accel_x;
      prev_y    <= in_data.accel_y;
      prev_z    <= in_data.accel_z;
      prev_time <= in_data.time_us;
      abs_x     <= dx[jsa_pkg::AXIS_W] ? jsa_pkg::AXIS_W'(-dx) : dx[jsa_pkg::AXIS_W-1:0];
      abs_y     <= dy[jsa_pkg::AXIS_W] ? jsa_pkg::AXIS_W'(-dy) : dy[jsa_pkg::AXIS_W-1:0];
      abs_z     <= dz[jsa_pkg::AXIS_W] ? jsa_pkg::AXIS_W'(-dz) : dz[jsa_pkg::AXIS_W-1:0];
      dt        <= in_data.time_us - prev_time;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  `JSA_ASSERT(a_alarm_rise,
    $rose(alarm) |-> $past(state == jsa_pkg::ST_BUSY && cnt == jsa_pkg::LAST_STEP),
    "alarm set outside a finished comparison")
  `JSA_ASSERT(a_alarm_fall,
    $fell(alarm) |-> ($past(rst) || $past(acc && is_tick && in_data.button_pressed)),
    "alarm cleared without a button tick")
  `JSA_ASSERT_RST(a_reset_state,
    rst |=> (first_sample && !alarm && !out_valid && state == jsa_pkg::ST_IDLE),
    "reset did not restore the detector")
  `JSA_ASSERT(a_buzz_needs_alarm,
    out_valid |-> (!out_data.buzzer_on || out_data.alarm_latched),
    "buzzer reported without a latched alarm")

endmodule

`default_nettype wire

[tb/sv/jsa_tb_pkg.sv]
// ----------------------------------------------------------------------------
// jsa_tb_pkg
// alarm status scoreboard: tracks the jerk trip test and the buzzer timing
// of the shock alarm and checks every status word the block returns
// ----------------------------------------------------------------------------
package jsa_tb_pkg;

  import jsa_pkg::*;

  // microseconds per second, squared
  localparam longint unsigned USEC_SQ = 64'd1000000000000;

  class shock_alarm_scoreboard;

    logic [THR_W-1:0]         jerk_thr;
    logic [TONE_W-1:0]        period_ms;
    logic [TONE_W-1:0]        on_ms;
    bit                       latched;
    bit                       await_first;
    bit                       rearm;
    logic [TONE_W-1:0]        ms_count;
    logic signed [AXIS_W-1:0] last_axis [3];
    logic [TIME_W-1:0]        last_time;
    out_item_t                expected_status [$];
    int unsigned              errors;

    function new();
      jerk_thr    = 24'd3276800;
      period_ms   = 16'd1000;
      on_ms       = 16'd500;
      latched     = 1'b0;
      await_first = 1'b1;
      rearm       = 1'b1;
      ms_count    = '0;
      last_axis   = '{default: '0};
      last_time   = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_JERK_THRESHOLD: jerk_thr = data[THR_W-1:0];
        REG_TONE_PERIOD:    period_ms = data[TONE_W-1:0];
        REG_TONE_ON:        on_ms = data[TONE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      logic signed [AXIS_W-1:0] cur [3];
      logic [TIME_W-1:0]        dt;
      longint unsigned          d2;
      longint                   diff;
      bit [127:0]               lhs;
      bit [127:0]               rhs;
      bit [127:0]               td;
      bit                       trip;
      bit                       start;
      out_item_t                status;
      cur[0] = it.accel_x;
      cur[1] = it.accel_y;
      cur[2] = it.accel_z;
      start  = 1'b0;
      if (!it.kind) begin
        if (!latched) begin
          if (!await_first) begin
            dt = it.time_us - last_time;
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
              diff = longint'(cur[i]) - longint'(last_axis[i]);
              d2 += longint'(diff * diff);
            end
            if (dt == 0) begin
              trip = (d2 != 0);
            end else begin
              // |d|^2 * 1e12 against (threshold * dt)^2, all exact
              lhs  = d2;
              lhs  = lhs * USEC_SQ;
              td   = jerk_thr;
              td   = td * dt;
              rhs  = td * td;
              trip = (lhs >= rhs);
            end
            if (trip) latched = 1'b1;
          end
          await_first = 1'b0;
          last_axis   = cur;
          last_time   = it.time_us;
        end
      end else if (latched) begin
        if (it.button_pressed) begin
          latched     = 1'b0;
          await_first = 1'b1;
          rearm       = 1'b1;
        end else if (rearm) begin
          rearm    = 1'b0;
          ms_count = '0;
          start    = 1'b1;
        end else begin
          if (ms_count != 16'hFFFF) ms_count++;
          if (ms_count >= period_ms) begin
            ms_count = '0;
            start    = 1'b1;
          end
        end
      end
      status.alarm_latched = latched;
      status.buzzer_on     = latched && !rearm && (ms_count < on_ms);
      status.tone_start    = start;
      expected_status.push_back(status);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        $error("status transfer with nothing expected: %b", got);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (got.alarm_latched !== want.alarm_latched) begin
        $error("alarm_latched: expected %b, actual %b", want.alarm_latched, got.alarm_latched);
        errors++;
      end
      if (got.buzzer_on !== want.buzzer_on) begin
        $error("buzzer_on: expected %b, actual %b", want.buzzer_on, got.buzzer_on);
        errors++;
      end
      if (got.tone_start !== want.tone_start) begin
        $error("tone_start: expected %b, actual %b", want.tone_start, got.tone_start);
        errors++;
      end
    endfunction

  endclass

endpackage

[tb/sv/jerk_shock_alarm_tb.sv]
// ----------------------------------------------------------------------------
// jerk_shock_alarm_tb
// drives samples and millisecond ticks into the shock alarm: a directed
// sweep of the trip boundary and buzzer corners, then random phases under
// several register settings and idle patterns, checked by a scoreboard
// ----------------------------------------------------------------------------
module jerk_shock_alarm_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import jsa_pkg::*;
  import jsa_tb_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SETTLE_CYCLES   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles = 0;

  logic signed [AXIS_W-1:0] gen_axis [3];
  logic [TIME_W-1:0]        gen_time;

  shock_alarm_scoreboard sb = new();

  jerk_shock_alarm dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // results are checked before the input of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_status(out_data);
      if (in_valid && in_ready) sb.note_item(in_data);
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic in_item_t accel_sample(int x, int y, int z, logic [TIME_W-1:0] t);
    in_item_t it;
    it         = '0;
    it.kind    = KIND_SAMPLE;
    it.accel_x = 16'(x);
    it.accel_y = 16'(y);
    it.accel_z = 16'(z);
    it.time_us = t;
    return it;
  endfunction

  function automatic in_item_t ms_tick(logic button);
    in_item_t it;
    it                = '0;
    it.kind           = KIND_TICK;
    it.button_pressed = button;
    return it;
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t          it;
    int                r;
    int                v;
    int                scale;
    logic [TIME_W-1:0] dt;
    longint unsigned   bound;
    it.accel_x        = 16'($urandom);
    it.accel_y        = 16'($urandom);
    it.accel_z        = 16'($urandom);
    it.time_us        = $urandom;
    it.button_pressed = 1'($urandom_range(1));
    r = $urandom_range(99);
    // mostly ticks while latched so the buzzer gets exercised, rare button
    if (sb.latched ? (r < 88) : (r < 12)) begin
      it.kind = KIND_TICK;
      if (sb.latched) it.button_pressed = 1'($urandom_range(99) < 4);
      return it;
    end
    it.kind = KIND_SAMPLE;
    if ($urandom_range(99) >= 15) begin
      r = $urandom_range(99);
      if (r < 6) dt = '0;
      else if (r < 88) dt = 32'($urandom_range(1, 2000));
      else dt = $urandom;
      // aim the change near the trip boundary threshold * dt / 1e6
      bound = (longint'(sb.jerk_thr) * dt) / 64'd1000000;
      scale = (bound > 60000) ? 60000 : int'(bound * 3 / 4) + 2;
      it.time_us = gen_time + dt;
      for (int i = 0; i < 3; i++) begin
        v = int'(gen_axis[i]) + int'($urandom_range(2 * scale)) - scale;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        gen_axis[i] = v[AXIS_W-1:0];
      end
      it.accel_x = gen_axis[0];
      it.accel_y = gen_axis[1];
      it.accel_z = gen_axis[2];
    end
    gen_time    = it.time_us;
    gen_axis[0] = it.accel_x;
    gen_axis[1] = it.accel_y;
    gen_axis[2] = it.accel_z;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    do @(negedge clk); while (sb.expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic write_config(logic [THR_W-1:0] thr, logic [TONE_W-1:0] per,
                              logic [TONE_W-1:0] on_t);
    write_reg(REG_UNUSED, 24'($urandom));
    write_reg(REG_JERK_THRESHOLD, thr);
    // upper bits of the tone registers are junk that must be dropped
    write_reg(REG_TONE_PERIOD, {8'($urandom), per});
    write_reg(REG_TONE_ON, {8'($urandom), on_t});
    cfg_write = 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [TONE_W-1:0] per;
    gen_time = '0;
    gen_axis = '{default: '0};
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset register values
    send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b1));
    send_item(accel_sample(32767, -32768, 0, 32'hFFFF_FFF0));
    send_item(accel_sample(32767, -32768, 0, 32'hFFFF_FFF0));
    send_item(accel_sample(-32768, 32767, -1, 32'h0000_0010));
    send_item(accel_sample(0, 0, 0, 32'h0000_0020));
    send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b1));
    send_item(accel_sample(0, 0, 0, 32'd100));
    send_item(accel_sample(1, 0, 0, 32'd100));
    send_item(ms_tick(1'b1));

    // exact equality trips; zero period and zero on-time
    wait_idle();
    write_config(24'd1000000, 16'd0, 16'd0);
    send_item(accel_sample(0, 0, 0, 32'd5));
    send_item(accel_sample(1, 0, 0, 32'd6));
    send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b1));

    // one count above equality holds; on-time longer than the period
    wait_idle();
    write_config(24'd1000001, 16'd3, 16'hFFFF);
    send_item(accel_sample(0, 0, 0, 32'd0));
    send_item(accel_sample(1, 0, 0, 32'd1));
    send_item(accel_sample(1001, 0, 0, 32'd2));
    repeat (4) send_item(ms_tick(1'b0));
    send_item(ms_tick(1'b1));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      case (p)
        0: write_config(24'd3276800, 16'd7, 16'd3);
        1: write_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        2: write_config(24'd0, 16'd1, 16'd0);
        default: begin
          per = 16'($urandom_range(2, 24));
          write_config(24'($urandom_range(20000, 9000000)), per,
                       16'($urandom_range(0, int'(per) + 4)));
        end
      endcase
      case (p % 4)
        1: send_idle_pct = 51;
        2: recv_stall_pct = 51;
        3: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
        default: ;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off the sender until the block has emptied
        if (p % 2 == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
        send_item(next_random_item());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
